FILE: rtl/sacf_pkg.sv
// Shared constants and types for the set-associative cache model.
`default_nettype none
package sacf_pkg;
    localparam int NUM_SETS_DEF   = 64;
    localparam int NUM_WAYS_DEF   = 8;
    localparam int ADDR_WIDTH_DEF = 48;
    localparam int ADDR_IN_W      = 48;
    localparam int CNT_W          = 32;

    // configuration register indexes
    localparam logic [1:0] REG_OFFSET_BITS = 2'd0;
    localparam logic [1:0] REG_SET_BITS    = 2'd1;
    localparam logic [1:0] REG_WAY_BITS    = 2'd2;
    localparam logic [1:0] REG_INDEX_MODE  = 2'd3;

    // controller to datapath commands
    typedef struct packed {
        logic load;     // capture input beat, start tag read
        logic update;   // compare, write back, register result
    } t_ctl_cmd;
endpackage
`default_nettype wire

FILE: rtl/set_assoc_cache_fifo_model_core.sv
// Top level of the tag-only set-associative cache model with FIFO replacement.
// Each access has two steps: reading its set's tag row and fill/pointer word
// from memory, then comparing, writing the victim way on a miss and loading the
// result register. One access is in flight at a time, so back-to-back accesses
// to a set see each other's updates. Config writes are taken only while no
// access is in flight and no input beat is offered; they do not flush the
// cache. After reset a clearing pass, one set at a time, zeroes the fill
// counts and victim pointers of NUM_SETS sets (64 by default), stalling input.
`default_nettype none
module set_assoc_cache_fifo_model_core
    import sacf_pkg::*;
#(
    parameter int NUM_SETS   = NUM_SETS_DEF,
    parameter int NUM_WAYS   = NUM_WAYS_DEF,
    parameter int ADDR_WIDTH = ADDR_WIDTH_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [1:0]           i_cfg_index,
    input  wire logic [31:0]          i_cfg_data,
    input  wire logic                 i_valid,
    output logic                      o_stall,
    input  wire logic                 i_kind,
    input  wire logic [ADDR_IN_W-1:0] i_address,
    output logic                      o_valid,
    input  wire logic                 i_stall,
    output logic                      o_hit,
    output logic                      o_mem_read,
    output logic                      o_mem_write,
    output logic [CNT_W-1:0]          o_hit_count,
    output logic [CNT_W-1:0]          o_miss_count,
    output logic [CNT_W-1:0]          o_read_count,
    output logic [CNT_W-1:0]          o_write_count
);
    logic [4:0] r_offset_bits;
    logic [2:0] r_set_bits;
    logic [1:0] r_way_bits;
    logic       r_index_mode;
    t_ctl_cmd   cmd;
    logic       clearing;
    logic       ctrl_idle;

    assign o_cfg_ready = ctrl_idle && !i_valid;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset_bits <= 5'd4;
            r_set_bits    <= 3'd6;
            r_way_bits    <= 2'd0;
            r_index_mode  <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                REG_OFFSET_BITS: r_offset_bits <= i_cfg_data[4:0];
                REG_SET_BITS:    r_set_bits    <= i_cfg_data[2:0];
                REG_WAY_BITS:    r_way_bits    <= i_cfg_data[1:0];
                REG_INDEX_MODE:  r_index_mode  <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    sacf_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_clearing(clearing), .i_valid(i_valid),
        .o_stall(o_stall), .o_valid(o_valid), .i_stall(i_stall), .o_idle(ctrl_idle),
        .o_cmd(cmd)
    );

    sacf_dpath #(.NUM_SETS(NUM_SETS), .NUM_WAYS(NUM_WAYS), .ADDR_WIDTH(ADDR_WIDTH)) u_dpath (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(cmd),
        .i_offset_bits(r_offset_bits), .i_set_bits(r_set_bits),
        .i_way_bits(r_way_bits), .i_index_mode(r_index_mode),
        .i_kind(i_kind), .i_address(i_address), .o_clearing(clearing),
        .o_hit(o_hit), .o_mem_read(o_mem_read), .o_mem_write(o_mem_write),
        .o_hit_count(o_hit_count), .o_miss_count(o_miss_count),
        .o_read_count(o_read_count), .o_write_count(o_write_count)
    );

    // a result is flagged as exactly one of hit or memory read
    a_hit_xor_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_hit != o_mem_read)) else $error("hit and mem_read disagree");
    // lookup and update never coincide
    a_cmd_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(cmd.load && cmd.update)) else $error("load during update");
    // an update always leads to a shown result
    a_update_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.update |=> o_valid) else $error("result missing after update");
endmodule
`default_nettype wire

FILE: rtl/sacf_ctrl.sv
// Controller: sequences lookup and update for one access at a time.
`default_nettype none
module sacf_ctrl
    import sacf_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_clearing,
    input  wire logic i_valid,
    output logic      o_stall,
    output logic      o_valid,
    input  wire logic i_stall,
    output logic      o_idle,
    output t_ctl_cmd  o_cmd
);
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_LOOK = 2'd1;
    localparam logic [1:0] ST_OUT  = 2'd2;

    logic [1:0] r_state, n_state;
    logic       out_free;

    // the result register may be reloaded when it is empty or being taken
    assign out_free = (r_state != ST_OUT) || !i_stall;
    assign o_valid  = (r_state == ST_OUT);
    assign o_stall  = i_clearing ||
                      !((r_state == ST_IDLE) || (r_state == ST_OUT && !i_stall));
    assign o_idle   = (r_state == ST_IDLE) && !i_clearing;
    assign o_cmd.load   = i_valid && !o_stall;
    assign o_cmd.update = (r_state == ST_LOOK);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (o_cmd.load) n_state = ST_LOOK;
            ST_LOOK: n_state = ST_OUT;
            ST_OUT: begin
                if (out_free) n_state = i_valid ? ST_LOOK : ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= ST_IDLE;
        else          r_state <= n_state;
    end
endmodule
`default_nettype wire

FILE: rtl/sacf_dpath.sv
// Datapath: address split, tag memory, per-set fill counts and victim pointers, counters.
`default_nettype none
module sacf_dpath
    import sacf_pkg::*;
#(
    parameter int NUM_SETS   = NUM_SETS_DEF,
    parameter int NUM_WAYS   = NUM_WAYS_DEF,
    parameter int ADDR_WIDTH = ADDR_WIDTH_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire t_ctl_cmd             i_cmd,
    input  wire logic [4:0]           i_offset_bits,
    input  wire logic [2:0]           i_set_bits,
    input  wire logic [1:0]           i_way_bits,
    input  wire logic                 i_index_mode,
    input  wire logic                 i_kind,
    input  wire logic [ADDR_IN_W-1:0] i_address,
    output logic                      o_clearing,
    output logic                      o_hit,
    output logic                      o_mem_read,
    output logic                      o_mem_write,
    output logic [CNT_W-1:0]          o_hit_count,
    output logic [CNT_W-1:0]          o_miss_count,
    output logic [CNT_W-1:0]          o_read_count,
    output logic [CNT_W-1:0]          o_write_count
);
    localparam int SET_W  = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
    localparam int WAY_W  = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;
    localparam int FILL_W = WAY_W + 1;
    // floor of log2: largest field size that still fits the store
    localparam int SLOG   = $clog2(NUM_SETS + 1) - 1;
    localparam int WLOG   = $clog2(NUM_WAYS + 1) - 1;
    localparam int AW_OFF = (ADDR_WIDTH < 16) ? ADDR_WIDTH : 16;
    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    typedef logic [ADDR_WIDTH-1:0] t_tag;

    // per-set state: ways filled so far (always a prefix) and FIFO pointer
    typedef struct packed {
        logic [FILL_W-1:0] fill;
        logic [WAY_W-1:0]  ptr;
    } t_meta;

    // effective field sizes
    logic [4:0]            eff_o;
    logic [2:0]            eff_s;
    logic [1:0]            eff_w;
    logic [ADDR_WIDTH-1:0] addr;
    logic [ADDR_WIDTH-1:0] sh_off;
    t_tag                  tag_c;
    logic [SET_W-1:0]      set_c;
    logic [6:0]            tag_bits;
    logic [ADDR_WIDTH-1:0] smask;
    logic [ADDR_WIDTH-1:0] tmask;
    logic [WAY_W:0]        ways;

    assign addr = ADDR_WIDTH'(i_address);

    always_comb begin
        eff_o = (i_offset_bits > 5'(AW_OFF)) ? 5'(AW_OFF) : i_offset_bits;
        eff_s = i_set_bits;
        for (int k = 0; k < 7; k++) begin
            if (eff_s > 3'd0 && ((32'(eff_s) > 32'(SLOG)) ||
                                 (32'(eff_o) + 32'(eff_s) > 32'(ADDR_WIDTH))))
                eff_s = eff_s - 3'd1;
        end
        eff_w = (32'(i_way_bits) > 32'(WLOG)) ? 2'(WLOG) : i_way_bits;
        ways = (WAY_W + 1)'(1) << eff_w;
        tag_bits = 7'(ADDR_WIDTH) - 7'(eff_o) - 7'(eff_s);
        smask = ~({ADDR_WIDTH{1'b1}} << eff_s);
        tmask = (tag_bits >= 7'(ADDR_WIDTH)) ? '1 : ~({ADDR_WIDTH{1'b1}} << tag_bits);
        sh_off = addr >> eff_o;
        if (!i_index_mode) begin
            set_c = SET_W'(sh_off & smask);
            tag_c = (sh_off >> eff_s) & tmask;
        end else begin
            set_c = (eff_s == 3'd0) ? '0
                  : SET_W'((addr >> (7'(ADDR_WIDTH) - 7'(eff_s))) & smask);
            tag_c = sh_off & tmask;
        end
    end

    // stage registers for the access in flight
    logic             r_kind;
    logic [SET_W-1:0] r_set;
    t_tag             r_tag;
    logic [WAY_W:0]   r_ways;
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_kind <= i_kind;
            r_set  <= set_c;
            r_tag  <= tag_c;
            r_ways <= ways;
        end
    end

    // tag memory and per-set state memory, registered reads
    t_tag [NUM_WAYS-1:0] mem_tag [NUM_SETS];
    t_tag [NUM_WAYS-1:0] r_row;
    t_meta               mem_meta [NUM_SETS];
    t_meta               r_meta;
    t_meta               n_meta;
    logic [WAY_W-1:0]    victim;
    logic [WAY_W-1:0]    wmask;
    logic                hit_c;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_row  <= mem_tag[set_c];
            r_meta <= mem_meta[set_c];
        end
    end

    always_comb begin
        wmask  = WAY_W'(r_ways - 1'b1);
        victim = r_meta.ptr & wmask;
        hit_c  = 1'b0;
        for (int k = 0; k < NUM_WAYS; k++) begin
            if ((WAY_W + 1)'(k) < r_ways && FILL_W'(k) < r_meta.fill && r_row[k] == r_tag)
                hit_c = 1'b1;
        end
        n_meta.fill = (FILL_W'(victim) == r_meta.fill) ? r_meta.fill + 1'b1 : r_meta.fill;
        n_meta.ptr  = (victim + 1'b1) & wmask;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.update && !hit_c) mem_tag[r_set][victim] <= r_tag;
    end

    // clearing pass after reset, one set per cycle
    logic [SET_W-1:0] r_clr_addr;
    logic             r_clearing;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clearing) begin
            r_clr_addr <= r_clr_addr + 1'b1;
            if (r_clr_addr == SET_W'(NUM_SETS - 1)) r_clearing <= 1'b0;
        end
    end
    assign o_clearing = r_clearing;

    always_ff @(posedge i_clk) begin
        if (r_clearing)                 mem_meta[r_clr_addr] <= '0;
        else if (i_cmd.update && !hit_c) mem_meta[r_set]     <= n_meta;
    end

    // result and saturating counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_hit_count   <= '0;
            o_miss_count  <= '0;
            o_read_count  <= '0;
            o_write_count <= '0;
        end else if (i_cmd.update) begin
            if (hit_c) begin
                if (o_hit_count != CNT_MAX) o_hit_count <= o_hit_count + 1'b1;
            end else begin
                if (o_miss_count != CNT_MAX) o_miss_count <= o_miss_count + 1'b1;
                if (o_read_count != CNT_MAX) o_read_count <= o_read_count + 1'b1;
            end
            if (r_kind && o_write_count != CNT_MAX) o_write_count <= o_write_count + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.update) begin
            o_hit       <= hit_c;
            o_mem_read  <= !hit_c;
            o_mem_write <= r_kind;
        end
    end
endmodule
`default_nettype wire

FILE: test/set_assoc_cache_fifo_model_core_test.sv
// Self-checking testbench for the set-associative FIFO cache model core.
`default_nettype none
module set_assoc_cache_fifo_model_core_test;
    import sacf_pkg::*;

    // one access outcome
    typedef struct packed {
        logic             hit;
        logic             mem_read;
        logic             mem_write;
        logic [CNT_W-1:0] hits;
        logic [CNT_W-1:0] misses;
        logic [CNT_W-1:0] reads;
        logic [CNT_W-1:0] writes;
    } t_outcome;

    // cache predictor plus queue of pending outcomes
    class cache_scoreboard;
        logic [4:0]  offset_bits;
        logic [2:0]  set_bits;
        logic [1:0]  way_bits;
        logic        index_mode;
        logic        valid_bit [NUM_SETS_DEF*NUM_WAYS_DEF];
        logic [47:0] tag_store [NUM_SETS_DEF*NUM_WAYS_DEF];
        int unsigned victim_ptr [NUM_SETS_DEF];
        logic [31:0] hits, misses, reads, writes;
        t_outcome    pending [$];
        int          errors;

        function void clear();
            offset_bits = 4; set_bits = 6; way_bits = 0; index_mode = 0;
            foreach (valid_bit[i]) begin
                valid_bit[i] = 0;
                tag_store[i] = '0;
            end
            foreach (victim_ptr[i]) victim_ptr[i] = 0;
            hits = 0; misses = 0; reads = 0; writes = 0;
            pending.delete();
            errors = 0;
        endfunction

        function void write_reg(logic [1:0] idx, logic [31:0] val);
            case (idx)
                REG_OFFSET_BITS: offset_bits = val[4:0];
                REG_SET_BITS:    set_bits    = val[2:0];
                REG_WAY_BITS:    way_bits    = val[1:0];
                REG_INDEX_MODE:  index_mode  = val[0];
                default: ;
            endcase
        endfunction

        static function logic [31:0] bump(logic [31:0] v);
            return (v == 32'hFFFF_FFFF) ? v : v + 1;
        endfunction

        // look up the access, update state, queue its outcome
        function void note_access(logic is_write, logic [47:0] addr);
            int unsigned o, s, w, ways, set, base, tbits, victim;
            logic [47:0] tag, tmask;
            t_outcome r;
            bit found;
            o = offset_bits > 16 ? 16 : offset_bits;
            s = set_bits;
            while (s > 0 && ((1 << s) > NUM_SETS_DEF || o + s > 48)) s--;
            w = way_bits;
            while (w > 0 && (1 << w) > NUM_WAYS_DEF) w--;
            ways = 1 << w;
            tbits = 48 - o - s;
            tmask = (tbits >= 48) ? '1 : ((48'd1 << tbits) - 1);
            if (!index_mode) begin
                set = (addr >> o) & ((1 << s) - 1);
                tag = (addr >> (o + s)) & tmask;
            end else begin
                set = (s == 0) ? 0 : (addr >> (48 - s)) & ((1 << s) - 1);
                tag = (addr >> o) & tmask;
            end
            if (set >= NUM_SETS_DEF) set = 0;
            base = set * NUM_WAYS_DEF;
            found = 0;
            for (int k = 0; k < ways; k++)
                if (valid_bit[base+k] && tag_store[base+k] == tag) found = 1;
            if (found) hits = bump(hits);
            else begin
                misses = bump(misses);
                reads = bump(reads);
                victim = victim_ptr[set] & (ways - 1);
                valid_bit[base+victim] = 1;
                tag_store[base+victim] = tag;
                victim_ptr[set] = (victim + 1) & (ways - 1);
            end
            if (is_write) writes = bump(writes);
            r.hit = found; r.mem_read = !found; r.mem_write = is_write;
            r.hits = hits; r.misses = misses; r.reads = reads; r.writes = writes;
            pending.push_back(r);
        endfunction

        function void check_result(t_outcome got);
            t_outcome want;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result %h", $time, got);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (got.hit != want.hit)
                $display("%0t: hit exp %0d got %0d", $time, want.hit, got.hit);
            if (got.mem_read != want.mem_read)
                $display("%0t: mem_read exp %0d got %0d", $time, want.mem_read,
                         got.mem_read);
            if (got.mem_write != want.mem_write)
                $display("%0t: mem_write exp %0d got %0d", $time, want.mem_write,
                         got.mem_write);
            if (got.hits != want.hits)
                $display("%0t: hit_count exp %0d got %0d", $time, want.hits, got.hits);
            if (got.misses != want.misses)
                $display("%0t: miss_count exp %0d got %0d", $time, want.misses,
                         got.misses);
            if (got.reads != want.reads)
                $display("%0t: read_count exp %0d got %0d", $time, want.reads, got.reads);
            if (got.writes != want.writes)
                $display("%0t: write_count exp %0d got %0d", $time, want.writes,
                         got.writes);
            if (got != want) errors++;
        endfunction
    endclass

    logic        i_clk = 0, i_rst_n = 0;
    logic        i_cfg_valid = 0;
    logic [1:0]  i_cfg_index = REG_OFFSET_BITS;
    logic [31:0] i_cfg_data = '0;
    logic        i_valid = 0, i_kind = 0, i_stall = 0;
    logic [47:0] i_address = '0;
    logic        o_cfg_ready, o_stall, o_valid, o_hit, o_mem_read, o_mem_write;
    logic [31:0] o_hit_count, o_miss_count, o_read_count, o_write_count;

    cache_scoreboard board = new();
    bit  quiet_tail = 0;
    bit  hold_off = 0;
    int  cycle_count = 0;

    set_assoc_cache_fifo_model_core uut (.*);

    initial forever #6 i_clk = ~i_clk;

    // run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 400000) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // result side: sample, check, random stall bursts
    initial begin
        int gap;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_valid && !i_stall)
                board.check_result({o_hit, o_mem_read, o_mem_write, o_hit_count,
                                    o_miss_count, o_read_count, o_write_count});
            if (hold_off) i_stall <= 1;
            else if (gap > 0) begin
                gap--;
                i_stall <= 1;
            end else begin
                i_stall <= 0;
                if (!quiet_tail && $urandom_range(0, 9) == 0) gap = $urandom_range(1, 19);
            end
        end
    end

    // recently used addresses, reused to get hits
    logic [47:0] recent [$];

    task automatic send_access(logic kind, logic [47:0] addr);
        i_valid   <= 1;
        i_kind    <= kind;
        i_address <= addr;
        do @(posedge i_clk); while (o_stall);
        board.note_access(kind, addr);
        recent.push_back(addr);
        if (recent.size() > 24) void'(recent.pop_front());
        if (!quiet_tail && $urandom_range(0, 7) == 0) begin
            i_valid <= 0;
            repeat ($urandom_range(1, 19)) @(posedge i_clk);
        end
    endtask

    task automatic write_reg(logic [1:0] idx, logic [31:0] val);
        i_cfg_valid <= 1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        board.write_reg(idx, val);
        i_cfg_valid <= 0;
    endtask

    task automatic drain();
        i_valid <= 0;
        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (6) @(posedge i_clk);
    endtask

    task automatic configure(int o, int s, int w, int m);
        drain();
        write_reg(REG_OFFSET_BITS, o);
        write_reg(REG_SET_BITS, s);
        write_reg(REG_WAY_BITS, w);
        write_reg(REG_INDEX_MODE, m);
    endtask

    function automatic logic [47:0] rand_addr();
        logic [47:0] a;
        a = 48'({$urandom, $urandom});
        // mostly narrow addresses so sets and tags collide
        case ($urandom_range(0, 3))
            0: a = a & 48'h3FFF;
            1: a = a & 48'hC000_0000_0FFF;
            2: a = a & 48'hFFFF;
            default: ;
        endcase
        if (recent.size() != 0 && $urandom_range(0, 2) == 0)
            a = recent[$urandom_range(0, recent.size() - 1)];
        return a;
    endfunction

    task automatic random_phase(int n);
        repeat (n) send_access(1'($urandom_range(0, 1)), rand_addr());
    endtask

    initial begin
        board.clear();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // directed: extremes, reads and writes, hits and FIFO eviction
        send_access(0, '0);
        send_access(1, '0);
        send_access(1, '1);
        send_access(0, '1);
        send_access(0, 48'h0000_0000_0400);
        send_access(0, '0);
        configure(16, 0, 3, 0);   // fully associative, 8 ways, big blocks
        for (int k = 0; k < 9; k++) send_access(k[0], 48'(k) << 16);
        send_access(0, '0);
        configure(31, 7, 3, 1);   // oversized fields clamp
        send_access(1, 48'hFFFF_0000_0000);
        send_access(0, 48'h5555_5555_5555);
        send_access(1, 48'hAAAA_AAAA_AAAA);
        drain();
        write_reg(REG_INDEX_MODE, 0);
        configure(0, 6, 2, 1);    // reconfigure without flush
        send_access(0, 48'h8000_0000_0001);
        send_access(0, 48'h8000_0000_0001);

        // random phases through several settings
        for (int p = 0; p < 8; p++) begin
            configure($urandom_range(0, 20), $urandom_range(0, 7),
                      $urandom_range(0, 3), $urandom_range(0, 1));
            random_phase(90);
        end

        // receiver holds off so the block fills and stalls its input
        hold_off = 1;
        fork
            random_phase(30);
            begin
                repeat (200) @(posedge i_clk);
                hold_off = 0;
            end
        join
        configure(4, 6, 0, 0);
        random_phase(150);
        quiet_tail = 1;
        configure(2, 3, 1, 0);
        random_phase(120);

        drain();
        repeat (20) @(posedge i_clk);
        if (board.errors == 0 && board.pending.size() == 0) $display("== PASS ==");
        else $display("== FAIL ==");
        $finish;
    end
endmodule
`default_nettype wire
